// ----- hw/rtl/sls_pkg.sv -----
// Status LED sequencer package: transaction types, palette, event and mode codes,
// and the elaboration-time constants for the phase divider and the quarter-wave sine table.
// No dependencies.
package sls_pkg;

  // Breathing waveform
  localparam int unsigned SINE_ENTRIES      = 1024;  // power of two, 64..4096
  localparam int unsigned BREATHE_PERIOD_MS = 3000;  // 100..60000

  localparam int unsigned SINE_W  = $clog2(SINE_ENTRIES);
  localparam int unsigned QUARTER = SINE_ENTRIES / 4;
  localparam int unsigned QTR_W   = SINE_W - 2;
  localparam int unsigned PHASE_W = $clog2(BREATHE_PERIOD_MS);
  localparam int unsigned MAG_W   = 15;
  localparam int unsigned SCALE_W = 17;
  localparam int unsigned SCALE_MID = 98304;          // 0.75 in Q17
  localparam int unsigned MAG_MAX   = 32767;
  localparam int unsigned Z_STEP    = (1 << 18) / SINE_ENTRIES;

  // Polynomial coefficients of the sine approximation
  localparam int unsigned SINE_A = 102944;
  localparam int unsigned SINE_B = 42334;
  localparam int unsigned SINE_C = 4926;

  // Residues of the byte weights of a 32-bit time modulo the period
  localparam int unsigned R8  = 256 % BREATHE_PERIOD_MS;
  localparam int unsigned R16 = 65536 % BREATHE_PERIOD_MS;
  localparam int unsigned R24 = (1 << 24) % BREATHE_PERIOD_MS;
  localparam int unsigned X_MAX = 255 * (R24 + R16 + R8) + 255;
  localparam int unsigned X_W   = $clog2(X_MAX + 1);

  // Reciprocal of the period, Q32, rounded down
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / 64'(BREATHE_PERIOD_MS);
  localparam int unsigned RECIP_W = $clog2(RECIP + 64'd1);
  localparam int unsigned QX_W = X_W + RECIP_W - RECIP_SHIFT;
  localparam int unsigned Y_W  = PHASE_W + SINE_W;
  localparam int unsigned QY_W = Y_W + RECIP_W - RECIP_SHIFT;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_FLASH_MS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE_STEP_MS = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] BOOT_FLASH_RST    = 16'd300;
  localparam logic [CFG_DATA_W-1:0] OVERRIDE_STEP_RST = 16'd1000;

  localparam logic [7:0] HOLD_FOREVER = 8'd255;

  typedef enum logic [2:0] {
    FUNC_TICK           = 3'd0,
    FUNC_BOOT           = 3'd1,
    FUNC_SET_MODE       = 3'd2,
    FUNC_SET_OVERRIDE   = 3'd3,
    FUNC_CLEAR_OVERRIDE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_FLASH  = 3'd1,
    MODE_RED    = 3'd2,
    MODE_GREEN  = 3'd3,
    MODE_ORANGE = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_time;
    logic [2:0]  mode_code;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  hold_seconds;
  } in_t;

  typedef struct packed {
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
    logic       override_shown;
  } out_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Colour decision carried down the pipeline next to the phase computation
  typedef struct packed {
    rgb_t base;
    logic breathe;
    logic shown;
  } job_t;

  // Per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic res;
  } pipe_en_t;

  localparam rgb_t WHITE = '{r: 8'd255, g: 8'd255, b: 8'd255};
  localparam rgb_t BLACK = '{r: 8'd0,   g: 8'd0,   b: 8'd0};

  function automatic rgb_t palette(input mode_e m);
    rgb_t c;
    case (m)
      MODE_FLASH:  c = WHITE;
      MODE_RED:    c = '{r: 8'd255, g: 8'd20, b: 8'd0};
      MODE_GREEN:  c = '{r: 8'd0,   g: 8'd80, b: 8'd0};
      MODE_ORANGE: c = '{r: 8'd255, g: 8'd80, b: 8'd0};
      default:     c = BLACK;
    endcase
    return c;
  endfunction

  // Sine magnitude at quarter-wave position kk (0..QUARTER), Q0.15
  function automatic logic [MAG_W-1:0] sine_mag(input int unsigned kk);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] inner;
    logic [63:0] mid;
    logic [63:0] s;
    z     = 64'(kk) * 64'(Z_STEP);
    z2    = (z * z) >> 16;
    inner = 64'(SINE_B) - ((z2 * 64'(SINE_C)) >> 16);
    mid   = 64'(SINE_A) - ((z2 * inner) >> 16);
    s     = ((z * mid) >> 16) >> 1;
    if (s > 64'(MAG_MAX)) s = 64'(MAG_MAX);
    return s[MAG_W-1:0];
  endfunction

  function automatic logic [QUARTER*MAG_W-1:0] sine_table();
    logic [QUARTER*MAG_W-1:0] tbl;
    tbl = '0;
    for (int k = 0; k < QUARTER; k++) begin
      tbl[k*MAG_W +: MAG_W] = sine_mag(k);
    end
    return tbl;
  endfunction

  localparam logic [QUARTER*MAG_W-1:0] SINE_TBL  = sine_table();
  localparam logic [MAG_W-1:0]         SINE_PEAK = sine_mag(QUARTER);

endpackage

// ----- hw/rtl/sls_ctrl.sv -----
// Event decoder and sequencer state: mode, boot flash, override countdown, config registers.
// Decides the colour source for tick and boot transactions.
// Depends on sls_pkg.
module sls_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sls_pkg::cfg_wr_t cfg_i,
  input  sls_pkg::in_t    item_i,
  input  logic            fire_i,
  output logic            has_result_o,
  output sls_pkg::job_t   job_o
);
  import sls_pkg::*;

  logic [CFG_DATA_W-1:0] boot_ms_q, boot_ms_d;
  logic [CFG_DATA_W-1:0] step_ms_q, step_ms_d;
  mode_e                 mode_q, mode_d;
  logic                  ov_on_q, ov_on_d;
  rgb_t                  ov_colour_q, ov_colour_d;
  logic [7:0]            ov_left_q, ov_left_d;
  logic [31:0]           ov_mark_q, ov_mark_d;
  logic [31:0]           flash_end_q, flash_end_d;

  logic [31:0] elapsed;
  logic        step_due;
  logic        flash_lit;

  assign elapsed   = item_i.now_time - ov_mark_q;
  assign step_due  = ov_on_q && (ov_left_q != HOLD_FOREVER) &&
                     (elapsed >= {16'b0, step_ms_q});
  assign flash_lit = item_i.now_time < flash_end_q;

  always_comb begin
    boot_ms_d    = boot_ms_q;
    step_ms_d    = step_ms_q;
    mode_d       = mode_q;
    ov_on_d      = ov_on_q;
    ov_colour_d  = ov_colour_q;
    ov_left_d    = ov_left_q;
    ov_mark_d    = ov_mark_q;
    flash_end_d  = flash_end_q;
    has_result_o = 1'b0;
    job_o        = '0;

    case (item_i.func)
      FUNC_TICK: begin
        has_result_o = 1'b1;
        if (step_due) begin
          ov_mark_d = ov_mark_q + {16'b0, step_ms_q};
          ov_left_d = ov_left_q - 8'd1;
          if (ov_left_q == 8'd1) ov_on_d = 1'b0;
        end
        if (ov_on_d) begin
          job_o.base  = ov_colour_q;
          job_o.shown = 1'b1;
        end else begin
          case (mode_q)
            MODE_FLASH: begin
              if (flash_lit) job_o.base = WHITE;
              else mode_d = MODE_OFF;
            end
            MODE_RED, MODE_GREEN, MODE_ORANGE: begin
              job_o.base    = palette(mode_q);
              job_o.breathe = 1'b1;
            end
            default: job_o.base = BLACK;
          endcase
        end
      end
      FUNC_BOOT: begin
        has_result_o = 1'b1;
        mode_d       = MODE_FLASH;
        flash_end_d  = item_i.now_time + {16'b0, boot_ms_q};
      end
      FUNC_SET_MODE: begin
        if (item_i.mode_code inside {MODE_OFF, MODE_RED, MODE_GREEN, MODE_ORANGE}) begin
          mode_d = mode_e'(item_i.mode_code);
        end
      end
      FUNC_SET_OVERRIDE: begin
        if (item_i.hold_seconds == 8'd0) begin
          ov_on_d   = 1'b0;
          ov_left_d = 8'd0;
        end else begin
          ov_colour_d = '{r: item_i.red_in, g: item_i.green_in, b: item_i.blue_in};
          ov_left_d   = item_i.hold_seconds;
          ov_on_d     = 1'b1;
          ov_mark_d   = item_i.now_time;
        end
      end
      FUNC_CLEAR_OVERRIDE: begin
        ov_on_d   = 1'b0;
        ov_left_d = 8'd0;
      end
      default: ;
    endcase

    if (cfg_i.valid && (cfg_i.index == CFG_BOOT_FLASH_MS)) boot_ms_d = cfg_i.data;
    if (cfg_i.valid && (cfg_i.index == CFG_OVERRIDE_STEP_MS)) step_ms_d = cfg_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_ms_q   <= BOOT_FLASH_RST;
      step_ms_q   <= OVERRIDE_STEP_RST;
      mode_q      <= MODE_OFF;
      ov_on_q     <= 1'b0;
      ov_colour_q <= BLACK;
      ov_left_q   <= 8'd0;
      ov_mark_q   <= 32'd0;
      flash_end_q <= 32'd0;
    end else begin
      boot_ms_q <= boot_ms_d;
      step_ms_q <= step_ms_d;
      if (fire_i) begin
        mode_q      <= mode_d;
        ov_on_q     <= ov_on_d;
        ov_colour_q <= ov_colour_d;
        ov_left_q   <= ov_left_d;
        ov_mark_q   <= ov_mark_d;
        flash_end_q <= flash_end_d;
      end
    end
  end

endmodule

// ----- hw/rtl/sls_phase.sv -----
// Phase pipeline: time modulo the breathing period, then the sine table index.
// Constant division by reciprocal multiply with one correction step. Depends on sls_pkg.
module sls_phase (
  input  logic                     clk_i,
  input  sls_pkg::pipe_en_t        en_i,
  input  logic [31:0]              now_i,
  input  sls_pkg::job_t            job_i,
  output logic [sls_pkg::SINE_W-1:0] idx_o,
  output sls_pkg::job_t            job_o
);
  import sls_pkg::*;

  logic [X_W-1:0]         x_d, x_q, x2_q;
  logic [X_W+RECIP_W-1:0] prod_x;
  logic [QX_W-1:0]        qe_q;
  logic [X_W-1:0]         qp, rem;
  logic [PHASE_W-1:0]     ph_d, ph_q, ph4_q;
  logic [Y_W-1:0]         y3, y4, q2p, rem2;
  logic [Y_W+RECIP_W-1:0] prod_y;
  logic [SINE_W-1:0]      q2e_d, q2e_q, idx_d, idx_q;
  job_t                   j1_q, j2_q, j3_q, j4_q, j5_q;

  // Fold the four bytes by their residues; stays far below 2^32
  assign x_d = X_W'(now_i[31:24]) * X_W'(R24) + X_W'(now_i[23:16]) * X_W'(R16) +
               X_W'(now_i[15:8]) * X_W'(R8) + X_W'(now_i[7:0]);

  assign prod_x = (X_W+RECIP_W)'(x_q) * (X_W+RECIP_W)'(RECIP);

  // Estimate is low by at most one period
  assign qp   = X_W'(qe_q) * X_W'(BREATHE_PERIOD_MS);
  assign rem  = x2_q - qp;
  assign ph_d = (rem >= X_W'(BREATHE_PERIOD_MS)) ? PHASE_W'(rem - X_W'(BREATHE_PERIOD_MS))
                                                 : PHASE_W'(rem);

  assign y3     = {ph_q, {SINE_W{1'b0}}};
  assign prod_y = (Y_W+RECIP_W)'(y3) * (Y_W+RECIP_W)'(RECIP);
  assign q2e_d  = SINE_W'(prod_y[Y_W+RECIP_W-1 -: QY_W]);

  assign y4    = {ph4_q, {SINE_W{1'b0}}};
  assign q2p   = Y_W'(q2e_q) * Y_W'(BREATHE_PERIOD_MS);
  assign rem2  = y4 - q2p;
  assign idx_d = q2e_q + SINE_W'(rem2 >= Y_W'(BREATHE_PERIOD_MS));

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      x_q  <= x_d;
      j1_q <= job_i;
    end
    if (en_i.s2) begin
      qe_q <= prod_x[X_W+RECIP_W-1 -: QX_W];
      x2_q <= x_q;
      j2_q <= j1_q;
    end
    if (en_i.s3) begin
      ph_q <= ph_d;
      j3_q <= j2_q;
    end
    if (en_i.s4) begin
      q2e_q <= q2e_d;
      ph4_q <= ph_q;
      j4_q  <= j3_q;
    end
    if (en_i.s5) begin
      idx_q <= idx_d;
      j5_q  <= j4_q;
    end
  end

  assign idx_o = idx_q;
  assign job_o = j5_q;

endmodule

// ----- hw/rtl/sls_shade.sv -----
// Shading stages: quarter-wave sine lookup to a Q17 scale, then per-channel scaling
// into the result register. Depends on sls_pkg.
module sls_shade (
  input  logic                       clk_i,
  input  sls_pkg::pipe_en_t          en_i,
  input  logic [sls_pkg::SINE_W-1:0] idx_i,
  input  sls_pkg::job_t              job_i,
  output sls_pkg::out_t              out_o
);
  import sls_pkg::*;

  logic [1:0]          quad;
  logic [QTR_W-1:0]    k;
  logic [QTR_W:0]      kk;
  logic [MAG_W-1:0]    mag;
  logic [SCALE_W-1:0]  scale_d, scale_q;
  job_t                j6_q;
  logic [SCALE_W+7:0]  prod_r, prod_g, prod_b;
  out_t                out_d, out_q;

  assign quad = idx_i[SINE_W-1 -: 2];
  assign k    = idx_i[QTR_W-1:0];
  // Mirror the odd quadrants; the top position is the peak entry
  assign kk   = quad[0] ? ((QTR_W+1)'(QUARTER) - {1'b0, k}) : {1'b0, k};
  assign mag  = kk[QTR_W] ? SINE_PEAK : SINE_TBL[kk[QTR_W-1:0]*MAG_W +: MAG_W];
  assign scale_d = quad[1] ? (SCALE_W'(SCALE_MID) - SCALE_W'(mag))
                           : (SCALE_W'(SCALE_MID) + SCALE_W'(mag));

  assign prod_r = (SCALE_W+8)'(j6_q.base.r) * (SCALE_W+8)'(scale_q);
  assign prod_g = (SCALE_W+8)'(j6_q.base.g) * (SCALE_W+8)'(scale_q);
  assign prod_b = (SCALE_W+8)'(j6_q.base.b) * (SCALE_W+8)'(scale_q);

  always_comb begin
    out_d.override_shown = j6_q.shown;
    if (j6_q.breathe) begin
      out_d.led_red   = prod_r[SCALE_W +: 8];
      out_d.led_green = prod_g[SCALE_W +: 8];
      out_d.led_blue  = prod_b[SCALE_W +: 8];
    end else begin
      out_d.led_red   = j6_q.base.r;
      out_d.led_green = j6_q.base.g;
      out_d.led_blue  = j6_q.base.b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s6) begin
      scale_q <= scale_d;
      j6_q    <= job_i;
    end
    if (en_i.res) out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

// ----- hw/rtl/status_led_sequencer_core.sv -----
// Status LED sequencer top level: input register, event control, phase and shading pipeline.
// Depends on sls_pkg, sls_ctrl, sls_phase, sls_shade.
//
//   channel  direction  handshake                 transaction payload
//   in       sink       in_valid_i / in_stall_o   in_data_i  (sls_pkg::in_t)
//   out      source     out_valid_o / out_stall_i out_data_o (sls_pkg::out_t)
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One transaction enters per cycle while in_stall_o is low. A tick or boot result passes
// from the input register through six pipeline stages to the output register; the depth is set by
// the two reciprocal-multiply divisions and the sine scaling. Other events update state
// when they leave the input register and produce nothing.
// Reset clears all valid flags and the sequencer state and restores boot_flash_ms 300 and
// override_step_ms 1000. An output stall backs up stage by stage; bubbles close up, and
// in_stall_o rises only once every stage holds a transaction. cfg_ready_o stays high.
module status_led_sequencer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  sls_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sls_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sls_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sls_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import sls_pkg::*;

  in_t      in_q;
  logic     in_valid_q;
  logic [6:1] s_valid_q;
  logic     out_valid_q;

  pipe_en_t en;
  logic     in_en;
  logic     fire;
  logic     has_result;
  job_t     job_s0;
  job_t     job_s5;
  logic [SINE_W-1:0] idx_s5;
  cfg_wr_t  cfg_wr;

  // Advance a stage when it is empty or its successor advances
  assign en.res = !out_valid_q || !out_stall_i;
  assign en.s6  = !s_valid_q[6] || en.res;
  assign en.s5  = !s_valid_q[5] || en.s6;
  assign en.s4  = !s_valid_q[4] || en.s5;
  assign en.s3  = !s_valid_q[3] || en.s4;
  assign en.s2  = !s_valid_q[2] || en.s3;
  assign en.s1  = !s_valid_q[1] || en.s2;
  assign in_en  = !in_valid_q || en.s1;
  assign fire   = in_valid_q && en.s1;

  assign in_stall_o  = !in_en;
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = 1'b1;

  assign cfg_wr = '{valid: cfg_valid_i, index: cfg_index_i, data: cfg_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      s_valid_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en)  in_valid_q   <= in_valid_i;
      // Drop events that produce no result here
      if (en.s1)  s_valid_q[1] <= in_valid_q && has_result;
      if (en.s2)  s_valid_q[2] <= s_valid_q[1];
      if (en.s3)  s_valid_q[3] <= s_valid_q[2];
      if (en.s4)  s_valid_q[4] <= s_valid_q[3];
      if (en.s5)  s_valid_q[5] <= s_valid_q[4];
      if (en.s6)  s_valid_q[6] <= s_valid_q[5];
      if (en.res) out_valid_q  <= s_valid_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en) in_q <= in_data_i;
  end

  sls_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .item_i       (in_q),
    .fire_i       (fire),
    .has_result_o (has_result),
    .job_o        (job_s0)
  );

  sls_phase u_phase (
    .clk_i (clk_i),
    .en_i  (en),
    .now_i (in_q.now_time),
    .job_i (job_s0),
    .idx_o (idx_s5),
    .job_o (job_s5)
  );

  sls_shade u_shade (
    .clk_i (clk_i),
    .en_i  (en),
    .idx_i (idx_s5),
    .job_i (job_s5),
    .out_o (out_data_o)
  );

  // Input backs up only when the whole pipeline is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&s_valid_q) && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // Tick and boot always enter the pipeline
  a_result_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.func == FUNC_TICK || in_q.func == FUNC_BOOT)) |=> s_valid_q[1])
    else $error("tick or boot transaction lost at decode");

  // A new result comes only from the last pipeline stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s_valid_q[6]))
    else $error("result appeared without a stage six transaction");

endmodule
